// ===== design/dss_pkg.sv =====
// dss_pkg: shared constants, codes and types of the disk seek scheduler.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none
package dss_pkg;

    localparam int MAX_REQ    = 16;
    localparam int CYL_BITS   = 16;
    localparam int SEEK_W     = 24;
    localparam int CNT_W      = $clog2(MAX_REQ + 1);
    localparam int ADDR_W     = $clog2(MAX_REQ);
    localparam int EMIT_W     = $clog2(MAX_REQ + 3);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 3;
    localparam int KIND_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLOOK = 3'd5;

    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIMIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRAP  = 2'd2;

    typedef struct packed {
        logic [CYL_BITS-1:0] pos;
        logic [KIND_W-1:0]   kind;
        logic                first;
        logic                last;
        logic                ovf;
    } t_visit;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [CYL_BITS-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
    } t_ram_rd;

endpackage
`default_nettype wire

// ===== design/dss_req_if.sv =====
// dss_req_if: request channel (valid/ready plus request payload).
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dss_req_if;
    import dss_pkg::*;
    logic                valid;
    logic                ready;
    logic [CYL_BITS-1:0] request_cylinder;
    logic                last_request;

    modport source (output valid, output request_cylinder, output last_request, input ready);
    modport sink   (input valid, input request_cylinder, input last_request, output ready);
endinterface
`default_nettype wire

// ===== design/dss_res_if.sv =====
// dss_res_if: result channel (valid/ready plus visit payload).
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dss_res_if;
    import dss_pkg::*;
    logic                valid;
    logic                ready;
    logic [CYL_BITS-1:0] visit_position;
    logic [KIND_W-1:0]   visit_kind;
    logic [SEEK_W-1:0]   total_seek;
    logic                overflow;
    logic                last_result;

    modport source (output valid, output visit_position, output visit_kind,
                    output total_seek, output overflow, output last_result, input ready);
    modport sink   (input valid, input visit_position, input visit_kind,
                    input total_seek, input overflow, input last_result, output ready);
endinterface
`default_nettype wire

// ===== design/disk_seek_scheduler.sv =====
// Disk seek scheduler top level: config registers, arrival and sorted stores.
// Requests load at one per cycle while in the load state; the closing request starts a rank
// sort run over the two read ports of the arrival store.
// Each result then passes issue, read, output register and handoff (once the result is
// taken), plus an extra issue step at each finished or empty sweep segment.
// Reset (synchronous, active low) empties the batch and restores the registers.
`timescale 1ns / 1ps
`default_nettype none
module disk_seek_scheduler (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [dss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [dss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    dss_req_if.sink                             i_req,
    dss_res_if.source                           o_res
);
    import dss_pkg::*;

    logic [CYL_BITS-1:0] r_head;
    logic [CYL_BITS-1:0] r_limit;
    logic [MODE_W-1:0]   r_mode;

    t_ram_wr             a_wr;
    t_ram_rd             a_rd;
    t_ram_wr             s_wr;
    t_ram_rd             s_rd;
    logic [CYL_BITS-1:0] a_rdata0;
    logic [CYL_BITS-1:0] a_rdata1;
    logic [CYL_BITS-1:0] s_rdata0;
    logic [CYL_BITS-1:0] s_rdata1;
    logic                start;
    t_visit              visit;
    logic                out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_limit <= '1;
            r_mode  <= MODE_FCFS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HEAD:  r_head  <= i_cfg_data[CYL_BITS-1:0];
                REG_LIMIT: r_limit <= i_cfg_data[CYL_BITS-1:0];
                REG_MODE:  r_mode  <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    dss_ram #(.DEPTH(MAX_REQ), .WIDTH(CYL_BITS)) u_arrival (
        .i_clk    (i_clk),
        .i_we     (a_wr.we),
        .i_waddr  (a_wr.addr),
        .i_wdata  (a_wr.data),
        .i_raddr0 (a_rd.addr0),
        .i_raddr1 (a_rd.addr1),
        .o_rdata0 (a_rdata0),
        .o_rdata1 (a_rdata1)
    );

    dss_ram #(.DEPTH(MAX_REQ), .WIDTH(CYL_BITS)) u_sorted (
        .i_clk    (i_clk),
        .i_we     (s_wr.we),
        .i_waddr  (s_wr.addr),
        .i_wdata  (s_wr.data),
        .i_raddr0 (s_rd.addr0),
        .i_raddr1 (s_rd.addr1),
        .o_rdata0 (s_rdata0),
        .o_rdata1 (s_rdata1)
    );

    dss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (r_head),
        .i_limit    (r_limit),
        .i_mode     (r_mode),
        .i_req      (i_req),
        .o_a_wr     (a_wr),
        .o_a_rd     (a_rd),
        .i_a_rdata0 (a_rdata0),
        .i_a_rdata1 (a_rdata1),
        .o_s_wr     (s_wr),
        .o_s_rd     (s_rd),
        .i_s_rdata0 (s_rdata0),
        .i_s_rdata1 (s_rdata1),
        .o_start    (start),
        .o_visit    (visit),
        .i_out_busy (out_busy)
    );

    dss_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_visit (visit),
        .i_head  (r_head),
        .o_busy  (out_busy),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire

// ===== design/dss_ram.sv =====
// dss_ram: generic synchronous RAM, one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dss_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= mem[i_raddr0];
        o_rdata1 <= mem[i_raddr1];
    end
endmodule
`default_nettype wire

// ===== design/dss_out.sv =====
// dss_out: result register, seek distance accumulation with saturation.
// Depends on dss_pkg and dss_res_if.
`timescale 1ns / 1ps
`default_nettype none
module dss_out (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire dss_pkg::t_visit         i_visit,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_head,
    output logic                         o_busy,
    dss_res_if.source                    o_res
);
    import dss_pkg::*;

    localparam int SUM_W = ((CYL_BITS > SEEK_W) ? CYL_BITS : SEEK_W) + 1;
    localparam logic [SUM_W-1:0] SAT = SUM_W'((64'd1 << SEEK_W) - 64'd1);

    logic                r_valid;
    logic [CYL_BITS-1:0] r_cur;
    logic [SEEK_W-1:0]   r_acc;
    logic [CYL_BITS-1:0] r_pos;
    logic [KIND_W-1:0]   r_kind;
    logic                r_ovf;
    logic                r_last;

    logic [CYL_BITS-1:0] from;
    logic [CYL_BITS-1:0] delta;
    logic [SUM_W-1:0]    sum;

    always_comb begin
        from  = i_visit.first ? i_head : r_cur;
        delta = (i_visit.pos >= from) ? (i_visit.pos - from) : (from - i_visit.pos);
        sum   = (i_visit.first ? '0 : SUM_W'(r_acc)) + SUM_W'(delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_start) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
        if (i_start) begin
            r_cur  <= i_visit.pos;
            r_acc  <= (sum > SAT) ? SEEK_W'(SAT) : SEEK_W'(sum);
            r_pos  <= i_visit.pos;
            r_kind <= i_visit.kind;
            r_ovf  <= i_visit.ovf;
            r_last <= i_visit.last;
        end
    end

    assign o_busy               = r_valid;
    assign o_res.valid          = r_valid;
    assign o_res.visit_position = r_pos;
    assign o_res.visit_kind     = r_kind;
    assign o_res.total_seek     = r_acc;
    assign o_res.overflow       = r_ovf;
    assign o_res.last_result    = r_last;
endmodule
`default_nettype wire

// ===== design/dss_ctrl.sv =====
// dss_ctrl: batch load, rank sort into the sorted store, sweep sequencer.
// Depends on dss_pkg and dss_req_if; drives two dss_ram instances.
`timescale 1ns / 1ps
`default_nettype none
module dss_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_head,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_limit,
    input  wire logic [dss_pkg::MODE_W-1:0]   i_mode,
    dss_req_if.sink                           i_req,
    output dss_pkg::t_ram_wr                  o_a_wr,
    output dss_pkg::t_ram_rd                  o_a_rd,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_a_rdata0,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_a_rdata1,
    output dss_pkg::t_ram_wr                  o_s_wr,
    output dss_pkg::t_ram_rd                  o_s_rd,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_s_rdata0,
    input  wire logic [dss_pkg::CYL_BITS-1:0] i_s_rdata1,
    output logic                              o_start,
    output dss_pkg::t_visit                   o_visit,
    input  wire logic                         i_out_busy
);
    import dss_pkg::*;

    localparam logic [2:0] S_LOAD    = 3'd0;
    localparam logic [2:0] S_RANK    = 3'd1;
    localparam logic [2:0] S_RANKEND = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_DECIDE2 = 3'd4;
    localparam logic [2:0] S_ISSUE   = 3'd5;
    localparam logic [2:0] S_DATA    = 3'd6;
    localparam logic [2:0] S_WAIT    = 3'd7;

    localparam logic [2:0] SG_NONE   = 3'd0;
    localparam logic [2:0] SG_ASC_S  = 3'd1;
    localparam logic [2:0] SG_DESC_S = 3'd2;
    localparam logic [2:0] SG_ASC_A  = 3'd3;
    localparam logic [2:0] SG_LIM    = 3'd4;
    localparam logic [2:0] SG_ZERO   = 3'd5;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic              r_p1_v;
    logic              r_p1_last;
    logic [CNT_W-1:0]  r_p1_i;
    logic [CNT_W-1:0]  r_p1_j;
    logic [CNT_W-1:0]  r_rank;
    logic [CNT_W-1:0]  r_pos;
    logic              r_up;
    logic [1:0]        r_seg;
    logic [CNT_W-1:0]  r_off;
    logic [EMIT_W-1:0] r_emit;
    logic [EMIT_W-1:0] r_total;
    logic [2:0]        r_src;
    logic              r_last_sent;

    logic [CNT_W-1:0]  n_rank;
    logic              less;
    logic              j_last;
    logic              i_last;
    logic [3:0]        plan;
    logic [2:0]        seg_typ;
    logic [CNT_W-1:0]  lo;
    logic [CNT_W-1:0]  hi;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  eaddr;
    logic              up_first;

    // segment plan: {type, upper-side flag}
    function automatic logic [3:0] seg_plan(input logic [MODE_W-1:0] mode, input logic up,
                                            input logic [1:0] seg);
        logic [3:0] p;
        p = {SG_NONE, 1'b0};
        unique case (mode)
            MODE_SSTF: begin
                if (seg == 2'd0) p = up ? {SG_ASC_S, 1'b1} : {SG_DESC_S, 1'b0};
                else if (seg == 2'd1) p = up ? {SG_DESC_S, 1'b0} : {SG_ASC_S, 1'b1};
            end
            MODE_SCAN: begin
                if (seg == 2'd0) p = {SG_ASC_S, 1'b1};
                else if (seg == 2'd1) p = {SG_LIM, 1'b0};
                else if (seg == 2'd2) p = {SG_DESC_S, 1'b0};
            end
            MODE_CSCAN: begin
                if (seg == 2'd0) p = {SG_ASC_S, 1'b1};
                else if (seg == 2'd1) p = {SG_LIM, 1'b0};
                else if (seg == 2'd2) p = {SG_ZERO, 1'b0};
                else p = {SG_ASC_S, 1'b0};
            end
            MODE_LOOK: begin
                if (seg == 2'd0) p = {SG_ASC_S, 1'b1};
                else if (seg == 2'd1) p = {SG_DESC_S, 1'b0};
            end
            MODE_CLOOK: begin
                if (seg == 2'd0) p = {SG_ASC_S, 1'b1};
                else if (seg == 2'd1) p = {SG_ASC_S, 1'b0};
            end
            default: begin
                if (seg == 2'd0) p = {SG_ASC_A, 1'b0};
            end
        endcase
        return p;
    endfunction

    always_comb begin
        less   = (i_a_rdata1 < i_a_rdata0) ||
                 ((i_a_rdata1 == i_a_rdata0) && (r_p1_j < r_p1_i));
        n_rank = r_rank + CNT_W'(less);
        j_last = (r_j == r_count - 1'b1);
        i_last = (r_i == r_count - 1'b1);

        plan    = seg_plan(i_mode, r_up, r_seg);
        seg_typ = plan[3:1];
        if (seg_typ == SG_ASC_A) begin
            lo = '0;
            hi = r_count;
        end else begin
            lo = plan[0] ? r_pos : '0;
            hi = plan[0] ? r_count : r_pos;
        end
        case (seg_typ)
            SG_ASC_S, SG_DESC_S, SG_ASC_A: len = hi - lo;
            SG_LIM, SG_ZERO:               len = CNT_W'(1);
            default:                       len = '0;
        endcase
        eaddr = (seg_typ == SG_DESC_S) ? (hi - 1'b1 - r_off) : (lo + r_off);

        if (r_pos == '0) up_first = 1'b1;
        else if (r_pos == r_count) up_first = 1'b0;
        else up_first = (i_s_rdata0 - i_head) < (i_head - i_s_rdata1);
    end

    always_comb begin
        o_a_wr.we    = (r_state == S_LOAD) && i_req.valid && (r_count < CNT_W'(MAX_REQ));
        o_a_wr.addr  = r_count[ADDR_W-1:0];
        o_a_wr.data  = i_req.request_cylinder;
        o_a_rd.addr0 = r_i[ADDR_W-1:0];
        o_a_rd.addr1 = (r_state == S_RANK) ? r_j[ADDR_W-1:0] : eaddr[ADDR_W-1:0];

        o_s_wr.we    = r_p1_v && r_p1_last;
        o_s_wr.addr  = n_rank[ADDR_W-1:0];
        o_s_wr.data  = i_a_rdata0;
        o_s_rd.addr0 = (r_state == S_DECIDE) ? r_pos[ADDR_W-1:0] : eaddr[ADDR_W-1:0];
        o_s_rd.addr1 = ADDR_W'(r_pos - 1'b1);

        o_start = (r_state == S_DATA);
        case (r_src)
            SG_LIM:   o_visit.pos = i_limit;
            SG_ZERO:  o_visit.pos = '0;
            SG_ASC_A: o_visit.pos = i_a_rdata1;
            default:  o_visit.pos = i_s_rdata0;
        endcase
        case (r_src)
            SG_LIM:  o_visit.kind = KIND_LIMIT;
            SG_ZERO: o_visit.kind = KIND_WRAP;
            default: o_visit.kind = KIND_REQ;
        endcase
        o_visit.first = (r_emit == '0);
        o_visit.last  = (r_emit == r_total - 1'b1);
        o_visit.ovf   = r_ovf;
    end

    assign i_req.ready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_p1_v  <= 1'b0;
        end else begin
            r_p1_v <= 1'b0;
            if (r_p1_v) begin
                if (r_p1_last) begin
                    r_rank <= '0;
                    if (i_a_rdata0 <= i_head) r_pos <= r_pos + 1'b1;
                end else begin
                    r_rank <= n_rank;
                end
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_req.valid) begin
                        if (r_count < CNT_W'(MAX_REQ)) r_count <= r_count + 1'b1;
                        else r_ovf <= 1'b1;
                        if (i_req.last_request) begin
                            r_state <= S_RANK;
                            r_i     <= '0;
                            r_j     <= '0;
                            r_rank  <= '0;
                            r_pos   <= '0;
                        end
                    end
                end
                S_RANK: begin
                    r_p1_v    <= 1'b1;
                    r_p1_last <= j_last;
                    r_p1_i    <= r_i;
                    r_p1_j    <= r_j;
                    if (j_last) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                        if (i_last) r_state <= S_RANKEND;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_RANKEND: r_state <= S_DECIDE;
                S_DECIDE:  r_state <= S_DECIDE2;
                S_DECIDE2: begin
                    r_up    <= up_first;
                    r_seg   <= '0;
                    r_off   <= '0;
                    r_emit  <= '0;
                    r_total <= EMIT_W'(r_count)
                             + ((i_mode == MODE_SCAN) ? EMIT_W'(1) : '0)
                             + ((i_mode == MODE_CSCAN) ? EMIT_W'(2) : '0);
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    if (r_off >= len) begin
                        r_seg <= r_seg + 1'b1;
                        r_off <= '0;
                    end else begin
                        r_src   <= seg_typ;
                        r_off   <= r_off + 1'b1;
                        r_state <= S_DATA;
                    end
                end
                S_DATA: begin
                    r_last_sent <= o_visit.last;
                    r_emit      <= r_emit + 1'b1;
                    r_state     <= S_WAIT;
                end
                S_WAIT: begin
                    if (!i_out_busy) begin
                        if (r_last_sent) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_REQ)) else $error("request count past capacity");
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_start |-> !i_out_busy) else $error("result issued while output busy");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_pos <= r_count)) else $error("split point past count");
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_emit < r_total)) else $error("emission overrun");
endmodule
`default_nettype wire

// ===== test/tb_disk_seek_scheduler.sv =====
// Testbench for disk_seek_scheduler: drives request batches under every schedule mode
// and varied register settings, predicts each visit sequence and checks results in order.
// Depends on dss_pkg, dss_req_if, dss_res_if and the design sources.
`timescale 1ns / 1ps
module tb_disk_seek_scheduler;
    import dss_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 400;
    localparam int WDOG_LIMIT  = 6000;

    typedef struct {
        logic [15:0] cyl;
        logic        last;
        logic        drain;
        int          gap;
    } req_item_t;

    typedef struct {
        logic [15:0] pos;
        logic [1:0]  kind;
        logic [23:0] seek;
        logic        ovf;
        logic        last;
    } seek_visit_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_HEAD;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dss_req_if req_ch ();
    dss_res_if res_ch ();

    disk_seek_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_res      (res_ch)
    );

    always #2 i_clk = ~i_clk;

    // scheduler state as seen by the predictor
    logic [15:0] pend_store[MAX_REQ];
    int          pend_count;
    logic        pend_ovf;
    logic [15:0] head_reg;
    logic [15:0] limit_reg;
    logic [2:0]  mode_reg;

    req_item_t   send_q[$];
    seek_visit_t visit_q[$];
    req_item_t   cur_req;
    logic        sending = 1'b0;
    int          gap_cnt = 0;
    logic        quiet = 1'b0;
    logic        hold_req = 1'b0;
    int          hold_cnt = 0;
    int          stall_cnt = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;

    task automatic report(input string what);
        mismatches++;
        $display("MISMATCH %s at %0t", what, $realtime);
    endtask

    // head walk for one closed batch
    logic [15:0] walk_pos;
    int unsigned walk_seek;
    seek_visit_t batch_visits[$];

    task automatic visit(input logic [15:0] p, input logic [1:0] k);
        seek_visit_t v;
        int unsigned d;
        d = (p >= walk_pos) ? p - walk_pos : walk_pos - p;
        walk_seek = walk_seek + d;
        if (walk_seek > 24'hFFFFFF)
            walk_seek = 24'hFFFFFF;
        walk_pos = p;
        v.pos = p;
        v.kind = k;
        v.seek = walk_seek[23:0];
        v.ovf = pend_ovf;
        v.last = 1'b0;
        batch_visits.push_back(v);
    endtask

    task automatic accept_request(input req_item_t it);
        logic [15:0] srt[MAX_REQ];
        logic [15:0] v;
        int n, i, j, split;
        logic up_first;
        if (pend_count < MAX_REQ) begin
            pend_store[pend_count] = it.cyl;
            pend_count++;
        end else begin
            pend_ovf = 1'b1;
        end
        if (!it.last)
            return;
        n = pend_count;
        walk_pos = head_reg;
        walk_seek = 0;
        batch_visits.delete();
        for (i = 0; i < n; i++) begin
            v = pend_store[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        split = 0;
        while (split < n && srt[split] <= head_reg)
            split++;
        case (mode_reg)
            MODE_SSTF: begin
                if (split == 0)
                    up_first = 1'b1;
                else if (split == n)
                    up_first = 1'b0;
                else
                    up_first = (srt[split] - head_reg) < (head_reg - srt[split-1]);
                if (up_first) begin
                    for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                    for (i = split; i > 0; i--) visit(srt[i-1], KIND_REQ);
                end else begin
                    for (i = split; i > 0; i--) visit(srt[i-1], KIND_REQ);
                    for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                end
            end
            MODE_SCAN: begin
                for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                visit(limit_reg, KIND_LIMIT);
                for (i = split; i > 0; i--) visit(srt[i-1], KIND_REQ);
            end
            MODE_CSCAN: begin
                for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                visit(limit_reg, KIND_LIMIT);
                visit(16'd0, KIND_WRAP);
                for (i = 0; i < split; i++) visit(srt[i], KIND_REQ);
            end
            MODE_LOOK: begin
                for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                for (i = split; i > 0; i--) visit(srt[i-1], KIND_REQ);
            end
            MODE_CLOOK: begin
                for (i = split; i < n; i++) visit(srt[i], KIND_REQ);
                for (i = 0; i < split; i++) visit(srt[i], KIND_REQ);
            end
            default: begin
                for (i = 0; i < n; i++) visit(pend_store[i], KIND_REQ);
            end
        endcase
        if (batch_visits.size() > 0)
            batch_visits[batch_visits.size()-1].last = 1'b1;
        foreach (batch_visits[i])
            visit_q.push_back(batch_visits[i]);
        pend_count = 0;
        pend_ovf = 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                accept_request(cur_req);
                sending = 1'b0;
            end
            if (!sending) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                    req_ch.valid <= 1'b0;
                end else if (send_q.size() > 0 && !(send_q[0].drain && visit_q.size() > 0)) begin
                    cur_req = send_q.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.request_cylinder <= cur_req.cyl;
                    req_ch.last_request <= cur_req.last;
                    sending = 1'b1;
                    gap_cnt = cur_req.gap;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        seek_visit_t e;
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                if (visit_q.size() == 0) begin
                    report($sformatf("unexpected result pos=%0d", res_ch.visit_position));
                end else begin
                    e = visit_q.pop_front();
                    if (res_ch.visit_position !== e.pos)
                        report($sformatf("position %0d, want %0d", res_ch.visit_position, e.pos));
                    if (res_ch.visit_kind !== e.kind)
                        report($sformatf("kind %0d, want %0d", res_ch.visit_kind, e.kind));
                    if (res_ch.total_seek !== e.seek)
                        report($sformatf("seek %0d, want %0d", res_ch.total_seek, e.seek));
                    if (res_ch.overflow !== e.ovf)
                        report($sformatf("overflow %0b, want %0b", res_ch.overflow, e.ovf));
                    if (res_ch.last_result !== e.last)
                        report($sformatf("last %0b, want %0b", res_ch.last_result, e.last));
                end
                stall_cnt = quiet ? 0 : $urandom_range(0, 16);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
            end else if (hold_req) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
            end
            res_ch.ready <= (hold_cnt == 0 && stall_cnt == 0);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_HEAD:  head_reg = val;
            REG_LIMIT: limit_reg = val;
            default:   mode_reg = val[2:0];
        endcase
    endtask

    task automatic settle();
        while (send_q.size() > 0 || sending || visit_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_cyl(input logic [15:0] h);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return h;
            3: return h + 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_batch(input int n, input logic drain);
        req_item_t it;
        for (int i = 0; i < n; i++) begin
            it.cyl = pick_cyl(head_reg);
            it.last = (i == n - 1);
            it.drain = drain && (i == 0);
            it.gap = quiet ? 0 : $urandom_range(0, 16);
            send_q.push_back(it);
        end
    endtask

    task automatic push_item(input logic [15:0] c, input logic l);
        req_item_t it;
        it.cyl = c;
        it.last = l;
        it.drain = 1'b0;
        it.gap = $urandom_range(0, 3);
        send_q.push_back(it);
    endtask

    initial begin
        int total, n;
        req_ch.valid = 1'b0;
        req_ch.request_cylinder = '0;
        req_ch.last_request = 1'b0;
        res_ch.ready = 1'b0;
        pend_count = 0;
        pend_ovf = 1'b0;
        head_reg = 16'd0;
        limit_reg = 16'hFFFF;
        mode_reg = MODE_FCFS;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: one batch before any register write
        push_item(16'd100, 1'b0);
        push_item(16'hFFFF, 1'b1);
        settle();

        // every mode around a mid head, both sides populated, plus a request at the head
        write_reg(REG_HEAD, 16'd1000);
        write_reg(REG_LIMIT, 16'hFFFF);
        for (int m = 0; m < 8; m++) begin
            write_reg(REG_MODE, 16'(m));
            push_item(16'd0, 1'b0);
            push_item(16'd1000, 1'b0);
            push_item(16'd2000, 1'b1);
            settle();
        end
        // empty upper side, limit below head
        write_reg(REG_HEAD, 16'hFFFF);
        write_reg(REG_LIMIT, 16'd0);
        for (int m = 1; m < 6; m++) begin
            write_reg(REG_MODE, 16'(m));
            push_item(16'd5, 1'b1);
            settle();
        end

        // random phases
        total = 0;
        for (int ph = 0; total < 230; ph++) begin
            write_reg(REG_HEAD, ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0) : 16'($urandom));
            write_reg(REG_LIMIT, ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0) : 16'($urandom));
            write_reg(REG_MODE, 16'($urandom_range(0, 7)));
            quiet = ($urandom_range(0, 3) == 0);
            if (ph == 2) begin
                quiet = 1'b1;
                hold_req = 1'b1;
            end
            for (int b = 0; b < 4; b++) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 6);
                push_batch(n, ($urandom_range(0, 3) == 0));
                total += n;
            end
            settle();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/dss_pkg.sv
design/dss_req_if.sv
design/dss_res_if.sv
design/dss_ram.sv
design/dss_out.sv
design/dss_ctrl.sv
design/disk_seek_scheduler.sv
test/tb_disk_seek_scheduler.sv
